FILE: sv/nshc_pkg.sv
// Shared constants, fixed-point formats and pipeline word types for the NTC
// Steinhart-Hart converter. No dependencies; every other file uses this package.
package nshc_pkg;

    // Input and configuration widths.
    localparam int ADC_BITS      = 10;
    localparam int LOG_FRAC_BITS = 24;
    localparam int SER_W         = 16;
    localparam int WIN_W         = 20;
    localparam int CFG_W         = 20;
    localparam int CFG_IDX_W     = 2;
    localparam int TEMP_W        = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SERIES = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MIN    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_MAX    = CFG_IDX_W'(2);

    localparam logic [SER_W-1:0] SER_RST = SER_W'(10080);
    localparam logic [WIN_W-1:0] MIN_RST = WIN_W'(1000);
    localparam logic [WIN_W-1:0] MAX_RST = WIN_W'(200000);

    // Resistance is Q20.8; in-window values stay below 2^R_W.
    localparam int RQ_FRAC = 8;
    localparam int R_W     = WIN_W + RQ_FRAC;
    localparam int NUM_W   = SER_W + ADC_BITS + RQ_FRAC;

    // Restoring divider cells, shared by both divisions.
    localparam int DIV_QW = (NUM_W > 39) ? NUM_W : 39;
    localparam int DIV_DW = 26;
    localparam logic [DIV_QW-1:0] RECIP_DVD = DIV_QW'(64'd100 << 32);
    localparam int RECIP_SHIFT = 28;

    // Output codes.
    localparam logic signed [TEMP_W-1:0] ERR_TEMP = TEMP_W'(9990);
    localparam int TEMP_MAX      = 32767;
    localparam int KELVIN0_CENTI = 27315;

    // Normalizer and log2 cells.
    localparam int NORM_W     = 32;
    localparam int NORM_STEPS = 5;
    localparam int Z_W        = $clog2(NORM_W);
    localparam int K_W        = 6;
    localparam int MANT_W     = 31;
    localparam int LOG_STEPS  = 30;
    localparam logic [29:0] LN2_Q30 = 30'd744261118;
    localparam int LN30_W   = 37;
    localparam int LN_SHIFT = 30 - LOG_FRAC_BITS;

    // Widths of ln R and its powers, sized from |ln R| < 16.
    localparam int L_W  = LOG_FRAC_BITS + 6;
    localparam int LA_W = LOG_FRAC_BITS + 4;
    localparam int L2_W = LOG_FRAC_BITS + 8;
    localparam int L3_W = LOG_FRAC_BITS + 12;

    // Steinhart-Hart coefficients in Q0.60, split at the product shift.
    localparam logic [63:0] C1_Q60 = 64'd1037629192394503;
    localparam logic [63:0] C2_Q60 = 64'd287524496750000;
    localparam logic [63:0] C3_Q60 = 64'd231819106840;
    localparam int C2_HI_W = 49 - LOG_FRAC_BITS;
    localparam int C3_HI_W = 38 - LOG_FRAC_BITS;
    localparam logic [C2_HI_W-1:0] C2_HI = C2_HI_W'(C2_Q60 >> LOG_FRAC_BITS);
    localparam logic [LOG_FRAC_BITS-1:0] C2_LO = LOG_FRAC_BITS'(C2_Q60);
    localparam logic [C3_HI_W-1:0] C3_HI = C3_HI_W'(C3_Q60 >> LOG_FRAC_BITS);
    localparam logic [LOG_FRAC_BITS-1:0] C3_LO = LOG_FRAC_BITS'(C3_Q60);
    localparam int MS_W = LA_W + C2_HI_W + 2;
    localparam int S_W  = MS_W + 2;

    // Cycles from an accepted word to its result strobe.
    localparam int LATENCY = 1 + DIV_QW + 1 + NORM_STEPS + LOG_STEPS + 8 + DIV_QW + 1;

    typedef struct packed {
        logic ok;
        logic szero;
    } t_tag;

    typedef struct packed {
        logic              vld;
        t_tag              tag;
        logic [DIV_DW-1:0] dvsr;
        logic [DIV_DW-1:0] rem;
        logic [DIV_QW-1:0] dvd;
        logic [DIV_QW-1:0] quo;
    } t_div;

    typedef struct packed {
        logic                  vld;
        logic                  ok;
        logic signed [K_W-1:0] k;
        logic [MANT_W-1:0]     mant;
        logic [LOG_STEPS-1:0]  frac;
    } t_log;

endpackage

FILE: sv/nshc_div_cell.sv
// One restoring-division cell: one quotient bit per cycle, registered.
// Depends on nshc_pkg (t_div, DIV_QW, DIV_DW).
module nshc_div_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  nshc_pkg::t_div i_stage,
    output nshc_pkg::t_div o_stage
);

    nshc_pkg::t_div r_stage;
    nshc_pkg::t_div n_stage;
    logic [nshc_pkg::DIV_DW:0] trial;
    logic [nshc_pkg::DIV_DW:0] diff;
    logic                      ge;

    always_comb begin
        trial = {i_stage.rem, i_stage.dvd[nshc_pkg::DIV_QW-1]};
        diff  = trial - {1'b0, i_stage.dvsr};
        ge    = (trial >= {1'b0, i_stage.dvsr});
        n_stage      = i_stage;
        n_stage.rem  = ge ? diff[nshc_pkg::DIV_DW-1:0] : trial[nshc_pkg::DIV_DW-1:0];
        n_stage.dvd  = {i_stage.dvd[nshc_pkg::DIV_QW-2:0], 1'b0};
        n_stage.quo  = {i_stage.quo[nshc_pkg::DIV_QW-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
        end else begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

FILE: sv/nshc_log_cell.sv
// One log2 cell: squares the Q1.30 mantissa and yields one fraction bit.
// Depends on nshc_pkg (t_log, MANT_W, LOG_STEPS).
module nshc_log_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  nshc_pkg::t_log i_stage,
    output nshc_pkg::t_log o_stage
);

    nshc_pkg::t_log r_stage;
    nshc_pkg::t_log n_stage;
    logic [2*nshc_pkg::MANT_W-1:0] sq;
    logic [nshc_pkg::MANT_W:0]     m2;
    logic                          big;

    assign sq = i_stage.mant * i_stage.mant;

    always_comb begin
        // The square is truncated back to Q2.30; a value of two or more halves it.
        m2  = sq[2*nshc_pkg::MANT_W-1:nshc_pkg::MANT_W-1];
        big = m2[nshc_pkg::MANT_W];
        n_stage      = i_stage;
        n_stage.mant = big ? m2[nshc_pkg::MANT_W:1] : m2[nshc_pkg::MANT_W-1:0];
        n_stage.frac = {i_stage.frac[nshc_pkg::LOG_STEPS-2:0], big};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
        end else begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

FILE: sv/ntc_steinhart_hart_converter.sv
// Top level of the NTC Steinhart-Hart converter: a fully pipelined chain of cells.
// Depends on nshc_pkg, nshc_div_cell and nshc_log_cell.
//
// Usage:
// An ADC word is taken at each rising edge where start is high and busy is low.
// busy never rises, so one word can be taken in every cycle, back to back.
// Each word yields exactly one result word: o_res_stb is high for one cycle with
// o_temp_centi_c and o_valid_res. The receiver cannot stall; results are not held.
// The latency is set by the two chains of restoring-division cells (one quotient
// bit per cell each) and the thirty log2 squaring cells, plus normalization and
// the polynomial stages in between.
// Configuration writes take effect at the edge where i_cfg_we is high; an index
// past the last register is ignored. They should only be issued with no word
// in flight, since the window is read mid-pipeline (the divider resistor at entry).
// Reset (synchronous, active low) restores the register defaults and drops all
// words still in flight; no result is strobed for them.
module ntc_steinhart_hart_converter (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [nshc_pkg::ADC_BITS-1:0]         i_adc_raw,
    input  logic                                  i_cfg_we,
    input  logic [nshc_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [nshc_pkg::CFG_W-1:0]            i_cfg_data,
    output logic                                  o_res_stb,
    output logic signed [nshc_pkg::TEMP_W-1:0]    o_temp_centi_c,
    output logic                                  o_valid_res
);

    localparam int QW   = nshc_pkg::DIV_QW;
    localparam int F    = nshc_pkg::LOG_FRAC_BITS;
    localparam int T_W  = 17;
    localparam int FLG_N = 7;

    typedef struct packed {
        logic                        vld;
        logic                        ok;
        logic [nshc_pkg::NORM_W-1:0] w;
        logic [nshc_pkg::Z_W-1:0]    z;
    } t_norm;

    typedef struct packed {
        logic vld;
        logic ok;
    } t_flag;

    // Configuration registers.
    logic [nshc_pkg::SER_W-1:0] r_series;
    logic [nshc_pkg::WIN_W-1:0] r_min;
    logic [nshc_pkg::WIN_W-1:0] r_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_series <= nshc_pkg::SER_RST;
            r_min    <= nshc_pkg::MIN_RST;
            r_max    <= nshc_pkg::MAX_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                nshc_pkg::REG_SERIES: r_series <= i_cfg_data[nshc_pkg::SER_W-1:0];
                nshc_pkg::REG_MIN:    r_min    <= i_cfg_data[nshc_pkg::WIN_W-1:0];
                nshc_pkg::REG_MAX:    r_max    <= i_cfg_data[nshc_pkg::WIN_W-1:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // Entry stage: numerator series*raw*256 and denominator 2^ADC_BITS - raw.
    nshc_pkg::t_div div1_q [0:QW];
    nshc_pkg::t_div n_div1;
    logic [nshc_pkg::NUM_W-1:0]    n_num;
    logic [nshc_pkg::ADC_BITS:0]   n_den;
    logic                          n_accept;

    assign n_accept = start && !busy;

    always_comb begin
        n_num = (nshc_pkg::NUM_W'(r_series) * nshc_pkg::NUM_W'(i_adc_raw))
                << nshc_pkg::RQ_FRAC;
        n_den = (nshc_pkg::ADC_BITS + 1)'(1 << nshc_pkg::ADC_BITS) - {1'b0, i_adc_raw};
        n_div1           = '0;
        n_div1.vld       = n_accept;
        n_div1.dvsr      = nshc_pkg::DIV_DW'(n_den);
        n_div1.dvd       = QW'(n_num);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            div1_q[0] <= '0;
        end else begin
            div1_q[0] <= n_div1;
        end
    end

    // Resistance division: one quotient bit per cell.
    for (genvar i = 0; i < QW; i++) begin : g_div1
        nshc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (div1_q[i]),
            .o_stage (div1_q[i+1])
        );
    end

    // Window check. A saturated or oversized resistance always fails it, so the
    // in-window value fits R_W bits and seeds the normalizer.
    t_norm r_nrm [0:nshc_pkg::NORM_STEPS];
    t_norm n_win;
    logic [QW-1:0] rq;

    always_comb begin
        rq        = div1_q[QW].quo;
        n_win.vld = div1_q[QW].vld;
        n_win.ok  = (rq > QW'({r_min, {nshc_pkg::RQ_FRAC{1'b0}}}))
                 && (rq < QW'({r_max, {nshc_pkg::RQ_FRAC{1'b0}}}));
        n_win.w   = nshc_pkg::NORM_W'(rq[nshc_pkg::R_W-1:0]);
        n_win.z   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nrm[0] <= '0;
        end else begin
            r_nrm[0] <= n_win;
        end
    end

    // Leading-zero normalization, halving the shift step at each stage.
    for (genvar g = 0; g < nshc_pkg::NORM_STEPS; g++) begin : g_norm
        localparam int SH = (nshc_pkg::NORM_W / 2) >> g;
        t_norm n_nrm;

        always_comb begin
            n_nrm = r_nrm[g];
            if (r_nrm[g].w[nshc_pkg::NORM_W-1 -: SH] == '0) begin
                n_nrm.w = r_nrm[g].w << SH;
                n_nrm.z = r_nrm[g].z + nshc_pkg::Z_W'(SH);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_nrm[g+1] <= '0;
            end else begin
                r_nrm[g+1] <= n_nrm;
            end
        end
    end

    // The integer part of log2 of R/256 is msb - 8; the mantissa is Q1.30.
    nshc_pkg::t_log log_q [0:nshc_pkg::LOG_STEPS];

    assign log_q[0] = '{
        vld:  r_nrm[nshc_pkg::NORM_STEPS].vld,
        ok:   r_nrm[nshc_pkg::NORM_STEPS].ok,
        k:    nshc_pkg::K_W'(nshc_pkg::NORM_W - 1 - nshc_pkg::RQ_FRAC)
              - nshc_pkg::K_W'(r_nrm[nshc_pkg::NORM_STEPS].z),
        mant: r_nrm[nshc_pkg::NORM_STEPS].w[nshc_pkg::NORM_W-1:1],
        frac: '0
    };

    for (genvar i = 0; i < nshc_pkg::LOG_STEPS; i++) begin : g_log
        nshc_log_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (log_q[i]),
            .o_stage (log_q[i+1])
        );
    end

    // Valid and window flags ride alongside the arithmetic stages.
    t_flag r_flg [0:FLG_N-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < FLG_N; i++) begin
                r_flg[i] <= '0;
            end
        end else begin
            r_flg[0] <= '{vld: log_q[nshc_pkg::LOG_STEPS].vld,
                          ok:  log_q[nshc_pkg::LOG_STEPS].ok};
            for (int i = 1; i < FLG_N; i++) begin
                r_flg[i] <= r_flg[i-1];
            end
        end
    end

    // Natural log: k*ln2 plus the fraction times ln2, then floored to F bits.
    logic signed [nshc_pkg::LN30_W-1:0]   k_ext;
    logic signed [nshc_pkg::LN30_W-1:0]   r_kp;
    logic [2*nshc_pkg::LOG_STEPS-1:0]     r_pf;
    logic signed [nshc_pkg::LN30_W-1:0]   ln30;
    logic signed [nshc_pkg::L_W-1:0]      r_l;

    assign k_ext = nshc_pkg::LN30_W'(log_q[nshc_pkg::LOG_STEPS].k);
    assign ln30  = r_kp + $signed(nshc_pkg::LN30_W'(
                       r_pf[2*nshc_pkg::LOG_STEPS-1:nshc_pkg::LOG_STEPS]));

    always_ff @(posedge i_clk) begin
        r_kp <= k_ext * $signed(nshc_pkg::LN30_W'(nshc_pkg::LN2_Q30));
        r_pf <= log_q[nshc_pkg::LOG_STEPS].frac * nshc_pkg::LN2_Q30;
        r_l  <= nshc_pkg::L_W'(ln30 >>> nshc_pkg::LN_SHIFT);
    end

    // Powers of ln R are formed on the magnitude and truncated toward zero;
    // the sign is put back when the terms are summed.
    logic                        r_neg_c, r_neg_d, r_neg_e, r_neg_f, r_neg_g;
    logic [nshc_pkg::LA_W-1:0]   r_la_c, r_la_d, r_la_e;
    logic [2*nshc_pkg::LA_W-1:0] sq_p;
    logic [nshc_pkg::L2_W-1:0]   r_l2;
    logic [nshc_pkg::L2_W+nshc_pkg::LA_W-1:0] cube_p;
    logic [nshc_pkg::L3_W-1:0]   r_l3;
    logic signed [nshc_pkg::L_W-1:0] l_neg;

    assign l_neg  = -r_l;
    assign sq_p   = r_la_c * r_la_c;
    assign cube_p = r_l2 * r_la_d;

    always_ff @(posedge i_clk) begin
        r_neg_c <= r_l[nshc_pkg::L_W-1];
        r_la_c  <= nshc_pkg::LA_W'(r_l[nshc_pkg::L_W-1] ? l_neg : r_l);
        r_neg_d <= r_neg_c;
        r_la_d  <= r_la_c;
        r_l2    <= nshc_pkg::L2_W'(sq_p >> F);
        r_neg_e <= r_neg_d;
        r_la_e  <= r_la_d;
        r_l3    <= nshc_pkg::L3_W'(cube_p >> F);
    end

    // Coefficient products, each split into high and low partial products.
    logic [nshc_pkg::LA_W+nshc_pkg::C2_HI_W-1:0] r_p2h;
    logic [nshc_pkg::LA_W+F-1:0]                 r_p2l;
    logic [nshc_pkg::L3_W+nshc_pkg::C3_HI_W-1:0] r_p3h;
    logic [nshc_pkg::L3_W+F-1:0]                 r_p3l;
    logic [nshc_pkg::LA_W+nshc_pkg::C2_HI_W-1:0] p2h;
    logic [nshc_pkg::LA_W+F-1:0]                 p2l;
    logic [nshc_pkg::L3_W+nshc_pkg::C3_HI_W-1:0] p3h;
    logic [nshc_pkg::L3_W+F-1:0]                 p3l;
    logic [nshc_pkg::MS_W-1:0]                   r_ms;

    assign p2h = r_la_e * nshc_pkg::C2_HI;
    assign p2l = r_la_e * nshc_pkg::C2_LO;
    assign p3h = r_l3 * nshc_pkg::C3_HI;
    assign p3l = r_l3 * nshc_pkg::C3_LO;

    always_ff @(posedge i_clk) begin
        r_p2h   <= p2h;
        r_p2l   <= p2l;
        r_p3h   <= p3h;
        r_p3l   <= p3l;
        r_neg_f <= r_neg_e;
        // (x*C) >> F equals x*C_hi + ((x*C_lo) >> F) exactly.
        r_ms    <= nshc_pkg::MS_W'(r_p2h) + nshc_pkg::MS_W'(r_p2l >> F)
                 + nshc_pkg::MS_W'(r_p3h) + nshc_pkg::MS_W'(r_p3l >> F);
        r_neg_g <= r_neg_f;
    end

    // Reciprocal kelvin sum, then the second division 100*2^32 / s.
    nshc_pkg::t_div div2_q [0:QW];
    nshc_pkg::t_div n_div2;
    logic [nshc_pkg::S_W-1:0] sum_s;

    always_comb begin
        sum_s = r_neg_g ? (nshc_pkg::S_W'(nshc_pkg::C1_Q60) - nshc_pkg::S_W'(r_ms))
                        : (nshc_pkg::S_W'(nshc_pkg::C1_Q60) + nshc_pkg::S_W'(r_ms));
        n_div2           = '0;
        n_div2.vld       = r_flg[FLG_N-1].vld;
        n_div2.dvsr      = nshc_pkg::DIV_DW'(sum_s >> nshc_pkg::RECIP_SHIFT);
        n_div2.tag.ok    = r_flg[FLG_N-1].ok && !sum_s[nshc_pkg::S_W-1] && (sum_s != '0);
        n_div2.tag.szero = (n_div2.dvsr == '0);
        n_div2.dvd       = nshc_pkg::RECIP_DVD;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            div2_q[0] <= '0;
        end else begin
            div2_q[0] <= n_div2;
        end
    end

    for (genvar i = 0; i < QW; i++) begin : g_div2
        nshc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (div2_q[i]),
            .o_stage (div2_q[i+1])
        );
    end

    // Result: subtract the kelvin offset. When the numerator is negative the
    // quotient must round toward zero, which adds one for a nonzero remainder.
    logic [QW-1:0]                     q;
    logic signed [T_W:0]               n_diff;
    logic signed [nshc_pkg::TEMP_W-1:0] n_temp;
    logic                              n_valid;

    always_comb begin
        q       = div2_q[QW].quo;
        n_diff  = $signed({1'b0, q[T_W-1:0]}) - (T_W + 1)'(nshc_pkg::KELVIN0_CENTI);
        n_temp  = nshc_pkg::ERR_TEMP;
        n_valid = 1'b0;
        if (div2_q[QW].tag.ok) begin
            n_valid = 1'b1;
            if (div2_q[QW].tag.szero
                || q > QW'(nshc_pkg::TEMP_MAX + nshc_pkg::KELVIN0_CENTI)) begin
                n_temp = nshc_pkg::TEMP_W'(nshc_pkg::TEMP_MAX);
            end else begin
                if (q < QW'(nshc_pkg::KELVIN0_CENTI) && div2_q[QW].rem != '0) begin
                    n_diff = n_diff + (T_W + 1)'(1);
                end
                n_temp = n_diff[nshc_pkg::TEMP_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_res_stb <= 1'b0;
        end else begin
            o_res_stb <= div2_q[QW].vld;
        end
        o_temp_centi_c <= n_temp;
        o_valid_res    <= n_valid;
    end

    // Every accepted word comes out after the fixed pipeline depth.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(nshc_pkg::LATENCY) o_res_stb)
        else $error("result strobe missing after pipeline latency");

    // An invalid result always carries the error code.
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_stb && !o_valid_res) |-> (o_temp_centi_c == nshc_pkg::ERR_TEMP))
        else $error("invalid result without error code");

    // A valid temperature never lies below absolute zero.
    a_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_stb && o_valid_res) |-> (o_temp_centi_c >= -16'sd27315))
        else $error("temperature below absolute zero");

    // In-window words leave the log chain with a normalized mantissa.
    a_mant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (log_q[nshc_pkg::LOG_STEPS].vld && log_q[nshc_pkg::LOG_STEPS].ok)
        |-> log_q[nshc_pkg::LOG_STEPS].mant[nshc_pkg::MANT_W-1])
        else $error("log2 mantissa lost normalization");

endmodule

FILE: bench/nshc_checker.sv
// Scoreboard for the NTC Steinhart-Hart converter: it mirrors the registers, predicts
// each temperature word and compares it with the strobed result. Depends on nshc_pkg.
module nshc_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic                                  i_busy,
    input  logic [nshc_pkg::ADC_BITS-1:0]         i_adc_raw,
    input  logic                                  i_cfg_we,
    input  logic [nshc_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [nshc_pkg::CFG_W-1:0]            i_cfg_data,
    input  logic                                  i_res_stb,
    input  logic signed [nshc_pkg::TEMP_W-1:0]    i_temp_centi_c,
    input  logic                                  i_valid_res,
    output int                                    o_fail_count,
    output int                                    o_pending
);

    typedef struct packed {
        logic signed [nshc_pkg::TEMP_W-1:0] temp;
        logic                               ok;
    } t_reading;

    logic [nshc_pkg::SER_W-1:0] series_ohm;
    logic [nshc_pkg::WIN_W-1:0] min_ohm;
    logic [nshc_pkg::WIN_W-1:0] max_ohm;
    t_reading                   reading_q[$];

    // Natural log of r/256 with LOG_FRAC_BITS fractional bits, by square-and-compare.
    function automatic longint ln_of_res(logic [31:0] r);
        int          e;
        logic [63:0] m;
        logic [63:0] f;
        longint      ln30;
        e = 31;
        while (e > 0 && !r[e]) e--;
        if (e <= 30) m = 64'(r) << (30 - e);
        else m = 64'(r) >> 1;
        f = '0;
        for (int i = 0; i < 30; i++) begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30)) begin
                m = m >> 1;
                f[29-i] = 1'b1;
            end
        end
        ln30 = longint'(e - 8) * longint'(nshc_pkg::LN2_Q30)
             + longint'((f * 64'(nshc_pkg::LN2_Q30)) >> 30);
        return ln30 >>> (30 - nshc_pkg::LOG_FRAC_BITS);
    endfunction

    // Product shifted right by LOG_FRAC_BITS, truncated toward zero.
    function automatic longint fix_mul(longint a, longint b);
        logic signed [127:0] p;
        logic [127:0]        mag;
        p = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
        mag = (p < 0) ? -p : p;
        mag = mag >> nshc_pkg::LOG_FRAC_BITS;
        return (p < 0) ? -longint'({1'b0, mag[62:0]}) : longint'({1'b0, mag[62:0]});
    endfunction

    function automatic t_reading steinhart_temp(logic [nshc_pkg::ADC_BITS-1:0] raw);
        logic [63:0] rq;
        longint      l1, l2, l3, sum, s, num, t;
        t_reading    res;
        rq = ((64'(series_ohm) * 64'(raw)) << nshc_pkg::RQ_FRAC)
           / ((64'd1 << nshc_pkg::ADC_BITS) - 64'(raw));
        if (rq > 64'hFFFF_FFFF) rq = 64'hFFFF_FFFF;
        res.temp = nshc_pkg::ERR_TEMP;
        res.ok = 1'b0;
        if (rq > (64'(min_ohm) << nshc_pkg::RQ_FRAC)
            && rq < (64'(max_ohm) << nshc_pkg::RQ_FRAC)) begin
            l1 = ln_of_res(rq[31:0]);
            l2 = fix_mul(l1, l1);
            l3 = fix_mul(l2, l1);
            sum = longint'(nshc_pkg::C1_Q60) + fix_mul(longint'(nshc_pkg::C2_Q60), l1)
                + fix_mul(longint'(nshc_pkg::C3_Q60), l3);
            if (sum > 0) begin
                s = sum >>> nshc_pkg::RECIP_SHIFT;
                res.ok = 1'b1;
                if (s == 0) begin
                    t = nshc_pkg::TEMP_MAX;
                end else begin
                    num = (longint'(100) <<< 32) - longint'(nshc_pkg::KELVIN0_CENTI) * s;
                    t = num / s;
                    if (t > nshc_pkg::TEMP_MAX) t = nshc_pkg::TEMP_MAX;
                    if (t < -nshc_pkg::KELVIN0_CENTI) t = -nshc_pkg::KELVIN0_CENTI;
                end
                res.temp = nshc_pkg::TEMP_W'(t);
            end
        end
        return res;
    endfunction

    assign o_pending = reading_q.size();

    always @(posedge i_clk) begin
        t_reading want;
        if (!i_rst_n) begin
            series_ohm <= nshc_pkg::SER_RST;
            min_ohm <= nshc_pkg::MIN_RST;
            max_ohm <= nshc_pkg::MAX_RST;
            reading_q.delete();
            o_fail_count <= 0;
        end else begin
            // Words in flight use the register values from before this edge.
            if (i_start && !i_busy) reading_q.push_back(steinhart_temp(i_adc_raw));
            if (i_res_stb) begin
                if (reading_q.size() == 0) begin
                    $error("result word with nothing expected: temp %0d valid %0b",
                           i_temp_centi_c, i_valid_res);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = reading_q.pop_front();
                    if (i_temp_centi_c !== want.temp || i_valid_res !== want.ok) begin
                        if (i_temp_centi_c !== want.temp)
                            $error("temp_centi_c: expected %0d, actual %0d",
                                   want.temp, i_temp_centi_c);
                        if (i_valid_res !== want.ok)
                            $error("valid_res: expected %0b, actual %0b",
                                   want.ok, i_valid_res);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    nshc_pkg::REG_SERIES: series_ohm <= i_cfg_data[nshc_pkg::SER_W-1:0];
                    nshc_pkg::REG_MIN:    min_ohm <= i_cfg_data[nshc_pkg::WIN_W-1:0];
                    nshc_pkg::REG_MAX:    max_ohm <= i_cfg_data[nshc_pkg::WIN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

FILE: bench/tb_ntc_steinhart_hart_converter.sv
// Testbench top for the NTC Steinhart-Hart converter: drives ADC words and register
// writes through several window settings. Depends on nshc_pkg and nshc_checker.
module tb_ntc_steinhart_hart_converter;

    // Index past the last register; writes to it must be ignored.
    localparam logic [nshc_pkg::CFG_IDX_W-1:0] REG_SPARE = nshc_pkg::CFG_IDX_W'(3);
    localparam int N_PHASES = 7;
    localparam int RANDOM_PER_PHASE = 300;
    // Longest stretch of cycles with no accepted word or result strobe.
    localparam int STALL_LIMIT = 4 * nshc_pkg::LATENCY + 2000;

    logic                                  i_clk;
    logic                                  i_rst_n;
    logic                                  start;
    logic                                  busy;
    logic [nshc_pkg::ADC_BITS-1:0]         i_adc_raw;
    logic                                  i_cfg_we;
    logic [nshc_pkg::CFG_IDX_W-1:0]        i_cfg_idx;
    logic [nshc_pkg::CFG_W-1:0]            i_cfg_data;
    logic                                  o_res_stb;
    logic signed [nshc_pkg::TEMP_W-1:0]    o_temp_centi_c;
    logic                                  o_valid_res;
    int                                    fail_count;
    int                                    pending;
    int                                    quiet_cycles;

    ntc_steinhart_hart_converter dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_adc_raw      (i_adc_raw),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_res_stb      (o_res_stb),
        .o_temp_centi_c (o_temp_centi_c),
        .o_valid_res    (o_valid_res)
    );

    nshc_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_adc_raw      (i_adc_raw),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_res_stb      (o_res_stb),
        .i_temp_centi_c (o_temp_centi_c),
        .i_valid_res    (o_valid_res),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // The watchdog ends the run if neither side moves a word for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_res_stb) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Mostly back to back, sometimes a short pause, rarely a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(3, 1);
        return $urandom_range(200, 20);
    endfunction

    // Holds one ADC word on the inputs until the converter takes it. With no gap
    // asked for, start stays high straight into the next word.
    task automatic send_word(logic [nshc_pkg::ADC_BITS-1:0] raw, int gap);
        start = 1'b1;
        i_adc_raw = raw;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        if (gap > 0) begin
            start = 1'b0;
            i_adc_raw = nshc_pkg::ADC_BITS'($urandom);
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic write_reg(logic [nshc_pkg::CFG_IDX_W-1:0] idx,
                             logic [nshc_pkg::CFG_W-1:0] data);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Lets every result arrive before the registers are touched again.
    task automatic drain();
        start = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (nshc_pkg::LATENCY + 4) @(negedge i_clk);
    endtask

    // Random words lean toward small and large readings, where the window edges live.
    function automatic logic [nshc_pkg::ADC_BITS-1:0] pick_raw();
        case ($urandom_range(3))
            0: return nshc_pkg::ADC_BITS'($urandom_range(40));
            1: return nshc_pkg::ADC_BITS'($urandom_range(1023, 983));
            default: return nshc_pkg::ADC_BITS'($urandom);
        endcase
    endfunction

    initial begin
        logic [nshc_pkg::ADC_BITS-1:0] edge_raw[] = '{0, 1, 2, 3, 4, 5, 90, 91, 92, 93,
                                                      511, 512, 513, 972, 973, 974,
                                                      1020, 1021, 1022, 1023};
        start = 1'b0;
        i_adc_raw = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = nshc_pkg::REG_SERIES;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            // Each phase sets up one window; phase zero runs on the reset values.
            case (ph)
                1: begin
                    write_reg(nshc_pkg::REG_SERIES, 20'hFFFF);
                    write_reg(nshc_pkg::REG_MIN, 20'd0);
                    write_reg(nshc_pkg::REG_MAX, 20'hFFFFF);
                end
                2: begin
                    // A tiny divider resistor gives sub-ohm readings, where the
                    // reciprocal goes negative or the temperature saturates.
                    write_reg(nshc_pkg::REG_SERIES, 20'd1);
                    write_reg(nshc_pkg::REG_MIN, 20'd0);
                    write_reg(nshc_pkg::REG_MAX, 20'hFFFFF);
                end
                3: begin
                    write_reg(nshc_pkg::REG_SERIES, 20'd10080);
                    write_reg(nshc_pkg::REG_MIN, 20'd1000);
                    write_reg(nshc_pkg::REG_MAX, 20'd200000);
                    write_reg(REG_SPARE, 20'h5A5A5);
                end
                4: begin
                    // Upper bits above the register width must be dropped.
                    write_reg(nshc_pkg::REG_SERIES, nshc_pkg::CFG_W'($urandom));
                    write_reg(nshc_pkg::REG_MIN, nshc_pkg::CFG_W'($urandom_range(5000)));
                    write_reg(nshc_pkg::REG_MAX,
                              nshc_pkg::CFG_W'($urandom_range(1048575, 5000)));
                end
                5: begin
                    // Empty window: minimum above maximum.
                    write_reg(nshc_pkg::REG_SERIES, 20'd10000);
                    write_reg(nshc_pkg::REG_MIN, 20'd500000);
                    write_reg(nshc_pkg::REG_MAX, 20'd100);
                end
                6: begin
                    write_reg(nshc_pkg::REG_SERIES, 20'd300);
                    write_reg(nshc_pkg::REG_MIN, 20'd0);
                    write_reg(nshc_pkg::REG_MAX, 20'd20);
                end
                default: ;
            endcase

            if (ph == 0 || ph == 2) begin
                foreach (edge_raw[i]) send_word(edge_raw[i], (i % 4 == 3) ? 2 : 0);
            end
            for (int n = 0; n < RANDOM_PER_PHASE; n++) send_word(pick_raw(), pick_gap());
            drain();
        end

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
